@@ rtl/lpct_pkg.sv @@
// Package for the linear-probe count table: field widths, defaults and shared types.
// Depends on nothing; every other file of the block but lpct_ram imports it.
`default_nettype none

package lpct_pkg;

   // Fixed field widths of the channels.
   localparam int KEY_W       = 64;
   localparam int HASH_W      = 64;
   localparam int CFG_W       = 13;
   localparam int SLOT_OUT_W  = 12;
   localparam int COUNT_OUT_W = 32;

   // Defaults for the top-level parameters.
   localparam int DEF_SLOTS      = 4096;
   localparam int DEF_COUNT_BITS = 32;

   // Reset value of the slot-count register.
   localparam logic [CFG_W-1:0] CFG_RESET = 13'd4096;

   // Remainder unit: four hash bits retired per cycle.
   localparam int DIV_RADIX_BITS = 4;
   localparam int DIV_STEPS      = HASH_W / DIV_RADIX_BITS;
   localparam int DIV_CNT_W      = $clog2(DIV_STEPS);

   // Status from the remainder unit to the probe sequencer.
   typedef struct packed {
      logic             busy;
      logic             done;
      logic [CFG_W-1:0] remainder;
   } rem_status_type;

endpackage

`default_nettype wire

@@ rtl/lpct_ifs.sv @@
// Channel interfaces of the linear-probe count table: request, response and register write.
// Depends on lpct_pkg for the field widths.
`default_nettype none

interface lpct_req_if;
   import lpct_pkg::*;
   logic              valid;
   logic              ready;
   logic [KEY_W-1:0]  item_key;
   logic [HASH_W-1:0] hash_value;

   modport source (output valid, output item_key, output hash_value, input ready);
   modport sink   (input valid, input item_key, input hash_value, output ready);
endinterface

interface lpct_rsp_if;
   import lpct_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [SLOT_OUT_W-1:0]  slot_index;
   logic [COUNT_OUT_W-1:0] new_count;
   logic                   table_full;

   modport source (output valid, output slot_index, output new_count, output table_full,
                   input ready);
   modport sink   (input valid, input slot_index, input new_count, input table_full,
                   output ready);
endinterface

interface lpct_csr_if;
   import lpct_pkg::*;
   logic             valid;
   logic             ready;
   logic [CFG_W-1:0] table_slots;

   modport source (output valid, output table_slots, input ready);
   modport sink   (input valid, input table_slots, output ready);
endinterface

`default_nettype wire

@@ rtl/lpct_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
`default_nettype none

module lpct_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/lpct_remainder.sv @@
// Iterative remainder unit: hash modulo slot count, four dividend bits per cycle.
// Depends on lpct_pkg.
`default_nettype none

module lpct_remainder (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [lpct_pkg::HASH_W-1:0] dividend,
   input  wire logic [lpct_pkg::CFG_W-1:0]  divisor,
   output lpct_pkg::rem_status_type         status
);
   import lpct_pkg::*;

   logic [HASH_W-1:0]    dvd_ff, dvd_in;
   logic [CFG_W-1:0]     rem_ff, rem_in;
   logic [CFG_W-1:0]     dsr_ff, dsr_in;
   logic [DIV_CNT_W-1:0] step_ff, step_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CFG_W-1:0]     rem_next;

   // Four restoring steps; the partial remainder stays below twice the divisor.
   always_comb begin
      logic [CFG_W:0] trial;
      logic [CFG_W-1:0] r;
      r = rem_ff;
      for (int i = 0; i < DIV_RADIX_BITS; i++) begin
         trial = {r, dvd_ff[HASH_W-1-i]};
         if (trial >= {1'b0, dsr_ff}) begin
            trial = trial - {1'b0, dsr_ff};
         end
         r = trial[CFG_W-1:0];
      end
      rem_next = r;
   end

   // Load on start, then shift the dividend through one digit per cycle.
   always_comb begin
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         dvd_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         dvd_in  = dvd_ff << DIV_RADIX_BITS;
         rem_in  = rem_next;
         step_in = step_ff + DIV_CNT_W'(1);
         if (step_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign status.busy      = busy_ff;
   assign status.done      = done_ff;
   assign status.remainder = rem_ff;

endmodule

`default_nettype wire

@@ rtl/lpct_probe.sv @@
// Probe sequencer of the count table: clearing pass, start-slot reduction, linear probing
// over the slot RAM, and the response register. Depends on lpct_pkg, lpct_ifs, lpct_ram
// and lpct_remainder.
`default_nettype none

module lpct_probe #(
   parameter int SLOTS      = lpct_pkg::DEF_SLOTS,
   parameter int COUNT_BITS = lpct_pkg::DEF_COUNT_BITS
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic [lpct_pkg::CFG_W-1:0] live_slots,
   lpct_req_if.sink                        req_ch,
   lpct_rsp_if.source                      rsp_ch
);
   import lpct_pkg::*;

   localparam int ADDR_W  = $clog2(SLOTS);
   localparam int ENTRY_W = KEY_W + COUNT_BITS;
   localparam int CMP_W   = ((ADDR_W > CFG_W) ? ADDR_W : CFG_W) + 1;

   typedef enum logic [5:0] {
      S_CLEAR  = 6'b000001,
      S_IDLE   = 6'b000010,
      S_DIV    = 6'b000100,
      S_READ   = 6'b001000,
      S_CHECK  = 6'b010000,
      S_FINISH = 6'b100000
   } probe_state_type;

   probe_state_type        state_ff, state_in;
   logic [KEY_W-1:0]       key_ff, key_in;
   logic [CFG_W-1:0]       n_ff, n_in;
   logic [ADDR_W-1:0]      x_ff, x_in;
   logic [CFG_W-1:0]       probes_ff, probes_in;
   logic [SLOT_OUT_W-1:0]  res_slot_ff, res_slot_in;
   logic [COUNT_OUT_W-1:0] res_count_ff, res_count_in;
   logic                   res_full_ff, res_full_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SLOT_OUT_W-1:0]  rsp_slot_ff, rsp_slot_in;
   logic [COUNT_OUT_W-1:0] rsp_count_ff, rsp_count_in;
   logic                   rsp_full_ff, rsp_full_in;

   logic                   div_start;
   rem_status_type         div_status;
   logic                   wr_en;
   logic [ENTRY_W-1:0]     wr_data;
   logic                   rd_en;
   logic [ENTRY_W-1:0]     rd_data;
   logic [KEY_W-1:0]       cur_key;
   logic [COUNT_BITS-1:0]  cur_count;
   logic [COUNT_BITS-1:0]  next_count;
   logic                   hit;
   logic                   last_probe;
   logic [CMP_W-1:0]       x_plus1;

   // Start slot: hash modulo the live slot count.
   lpct_remainder u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (req_ch.hash_value),
      .divisor  (live_slots),
      .status   (div_status)
   );

   // Slot store: key in the upper bits, count in the lower bits.
   lpct_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SLOTS)
   ) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (x_ff),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (x_ff),
      .rd_data (rd_data)
   );

   // Slot compare and probe bookkeeping.
   assign cur_key    = rd_data[ENTRY_W-1:COUNT_BITS];
   assign cur_count  = rd_data[COUNT_BITS-1:0];
   assign next_count = cur_count + COUNT_BITS'(1);
   assign hit        = (cur_key == '0) || (cur_key == key_ff);
   assign x_plus1    = CMP_W'(x_ff) + CMP_W'(1);
   assign last_probe = (CMP_W'(probes_ff) + CMP_W'(1)) == CMP_W'(n_ff);

   assign req_ch.ready = (state_ff == S_IDLE);

   // Sequencer and datapath next values.
   always_comb begin
      state_in     = state_ff;
      key_in       = key_ff;
      n_in         = n_ff;
      x_in         = x_ff;
      probes_in    = probes_ff;
      res_slot_in  = res_slot_ff;
      res_count_in = res_count_ff;
      res_full_in  = res_full_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ch.ready;
      rsp_slot_in  = rsp_slot_ff;
      rsp_count_in = rsp_count_ff;
      rsp_full_in  = rsp_full_ff;
      div_start    = 1'b0;
      wr_en        = 1'b0;
      wr_data      = '0;
      rd_en        = 1'b0;

      unique case (state_ff)
         S_CLEAR: begin
            wr_en = 1'b1;
            if (x_ff == ADDR_W'(SLOTS - 1)) begin
               x_in     = '0;
               state_in = S_IDLE;
            end else begin
               x_in = x_ff + ADDR_W'(1);
            end
         end
         S_IDLE: begin
            if (req_ch.valid) begin
               key_in    = req_ch.item_key;
               n_in      = live_slots;
               div_start = 1'b1;
               state_in  = S_DIV;
            end
         end
         S_DIV: begin
            if (div_status.done) begin
               x_in      = ADDR_W'(div_status.remainder);
               probes_in = '0;
               state_in  = S_READ;
            end
         end
         S_READ: begin
            rd_en    = 1'b1;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (hit) begin
               // Match or empty slot: claim it and bump the count.
               wr_en        = 1'b1;
               wr_data      = {key_ff, next_count};
               res_slot_in  = SLOT_OUT_W'(x_ff);
               res_count_in = COUNT_OUT_W'(next_count);
               res_full_in  = 1'b0;
               state_in     = S_FINISH;
            end else if (last_probe) begin
               // Every live slot visited without success.
               res_slot_in  = '0;
               res_count_in = '0;
               res_full_in  = 1'b1;
               state_in     = S_FINISH;
            end else begin
               probes_in = probes_ff + CFG_W'(1);
               x_in      = (x_plus1 == CMP_W'(n_ff)) ? '0 : x_plus1[ADDR_W-1:0];
               state_in  = S_READ;
            end
         end
         S_FINISH: begin
            // Hand over to the response register once it is free.
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_slot_in  = res_slot_ff;
               rsp_count_in = res_count_ff;
               rsp_full_in  = res_full_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         x_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         x_ff         <= x_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      key_ff       <= key_in;
      n_ff         <= n_in;
      probes_ff    <= probes_in;
      res_slot_ff  <= res_slot_in;
      res_count_ff <= res_count_in;
      res_full_ff  <= res_full_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_count_ff <= rsp_count_in;
      rsp_full_ff  <= rsp_full_in;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.slot_index = rsp_slot_ff;
   assign rsp_ch.new_count  = rsp_count_ff;
   assign rsp_ch.table_full = rsp_full_ff;

endmodule

`default_nettype wire

@@ rtl/linear_probe_count_table.sv @@
// Linear-probe count table: open-addressing key counter over one slot RAM.
// Each item: the hash is reduced to a start slot by the iterative remainder unit, then each
// probed slot is read and then checked, and the result passes into the response register.
// One item at a time: a request is taken only once the last result is in the response register; a response
// still held by the receiver delays the next one until it is taken.
// After reset a clearing pass writes every slot to zero, with no request taken;
// the slot-count register resets to 4096 and accepts writes at any time.
// Depends on lpct_pkg, lpct_ifs, lpct_probe.
`default_nettype none

module linear_probe_count_table #(
   parameter int SLOTS      = lpct_pkg::DEF_SLOTS,
   parameter int COUNT_BITS = lpct_pkg::DEF_COUNT_BITS
) (
   input wire logic   clock,
   input wire logic   reset,
   lpct_req_if.sink   req_ch,
   lpct_rsp_if.source rsp_ch,
   lpct_csr_if.sink   csr_ch
);
   import lpct_pkg::*;

   logic [CFG_W-1:0] table_slots_ff, table_slots_in;
   logic [CFG_W-1:0] live_slots;

   // Slot-count register, written on a configuration transfer.
   assign csr_ch.ready = 1'b1;

   always_comb begin
      table_slots_in = table_slots_ff;
      if (csr_ch.valid) begin
         table_slots_in = csr_ch.table_slots;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         table_slots_ff <= CFG_RESET;
      end else begin
         table_slots_ff <= table_slots_in;
      end
   end

   // Zero acts as one slot, and anything above the RAM depth as the full depth.
   always_comb begin
      if (table_slots_ff == '0) begin
         live_slots = CFG_W'(1);
      end else if (32'(table_slots_ff) > 32'(SLOTS)) begin
         live_slots = CFG_W'(SLOTS);
      end else begin
         live_slots = table_slots_ff;
      end
   end

   lpct_probe #(
      .SLOTS      (SLOTS),
      .COUNT_BITS (COUNT_BITS)
   ) u_probe (
      .clock      (clock),
      .reset      (reset),
      .live_slots (live_slots),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch)
   );

endmodule

`default_nettype wire
